[rtl/core/totp_pkg.sv]
// Shared types, constants and helper functions for the one-time code verifier.
`default_nettype none
package totp_pkg;

  localparam int unsigned MaxWindow = 15;

  localparam logic [159:0] Sha1Iv =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

  // Message length in bits of the inner (72-byte) and outer (84-byte) hash inputs.
  localparam logic [63:0] InnerLenBits = 64'd576;
  localparam logic [63:0] OuterLenBits = 64'd672;

  localparam logic [2:0] RegKeyHigh = 3'd0;
  localparam logic [2:0] RegKeyMid  = 3'd1;
  localparam logic [2:0] RegKeyLow  = 3'd2;
  localparam logic [2:0] RegDigits  = 3'd3;
  localparam logic [2:0] RegWindow  = 3'd4;
  localparam logic [2:0] RegOffset  = 3'd5;

  // Which of the four compressions of one HMAC is running.
  localparam logic [1:0] BlkInnerKey = 2'd0;
  localparam logic [1:0] BlkInnerMsg = 2'd1;
  localparam logic [1:0] BlkOuterKey = 2'd2;
  localparam logic [1:0] BlkOuterMsg = 2'd3;

  typedef enum logic [2:0] {
    StIdle,
    StHashGo,
    StHashRun,
    StModGo,
    StModRun,
    StCheck,
    StReport
  } state_e;

  typedef struct packed {
    logic load;
    logic sha_start;
    logic sha_capture;
    logic mod_start;
    logic next_shift;
    logic result_set;
  } cmd_t;

  typedef struct packed {
    logic sha_done;
    logic last_blk;
    logic mod_done;
    logic match;
    logic last_shift;
  } sts_t;

  function automatic logic [29:0] pow10(input logic [3:0] d);
    logic [29:0] r;
    case (d)
      4'd0:    r = 30'd1;
      4'd1:    r = 30'd10;
      4'd2:    r = 30'd100;
      4'd3:    r = 30'd1000;
      4'd4:    r = 30'd10000;
      4'd5:    r = 30'd100000;
      4'd6:    r = 30'd1000000;
      4'd7:    r = 30'd10000000;
      4'd8:    r = 30'd100000000;
      4'd9:    r = 30'd1000000000;
      default: r = 30'd1;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/totp_sha1.sv]
// SHA-1 compression unit: one round per cycle, 80 rounds per 512-bit block.
`default_nettype none
module totp_sha1 import totp_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [159:0] h_i,
  input  wire logic [511:0] blk_i,
  output logic              busy_o,
  output logic [159:0]      digest_o
);

  logic [159:0] h_q;
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [31:0]  w_q [16];
  logic [6:0]   rnd_q;
  logic         busy_q;

  logic [31:0] f, k, t, w_new, x;

  always_comb begin
    if (rnd_q inside {[7'd0:7'd19]}) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = 32'h5A827999;
    end else if (rnd_q inside {[7'd20:7'd39]}) begin
      f = b_q ^ c_q ^ d_q;
      k = 32'h6ED9EBA1;
    end else if (rnd_q inside {[7'd40:7'd59]}) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = 32'h8F1BBCDC;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = 32'hCA62C1D6;
    end
    t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
    // Schedule taps sit at t-3, t-8, t-14 and t-16 relative to the word being formed.
    x = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    w_new = {x[30:0], x[31]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      rnd_q  <= '0;
    end else if (busy_q) begin
      rnd_q <= rnd_q + 7'd1;
      if (rnd_q == 7'd79) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      h_q <= h_i;
      a_q <= h_i[159:128];
      b_q <= h_i[127:96];
      c_q <= h_i[95:64];
      d_q <= h_i[63:32];
      e_q <= h_i[31:0];
      for (int i = 0; i < 16; i++) begin
        w_q[i] <= blk_i[511 - 32*i -: 32];
      end
    end else if (busy_q) begin
      e_q <= d_q;
      d_q <= c_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      b_q <= a_q;
      a_q <= t;
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w_new;
    end
  end

  assign busy_o   = busy_q;
  assign digest_o = {h_q[159:128] + a_q, h_q[127:96] + b_q, h_q[95:64] + c_q,
                     h_q[63:32] + d_q, h_q[31:0] + e_q};

endmodule
`default_nettype wire

[rtl/core/totp_dp.sv]
// Datapath: configuration registers, HMAC block assembly, truncation, reduction, compare.
`default_nettype none
module totp_dp import totp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic [30:0] minute_count_i,
  input  wire logic [29:0] claimed_code_i,
  input  wire cmd_t        cmd_i,
  output sts_t             sts_o,
  output logic             code_matches_o
);

  logic [63:0] key_high_q, key_mid_q;
  logic [31:0] key_low_q;
  logic [3:0]  digits_q, window_q;
  logic [15:0] offset_q;

  logic [29:0]  claimed_q;
  logic [31:0]  ctr_q;
  logic [4:0]   sidx_q;
  logic [1:0]   blk_q;
  logic [159:0] hst_q, inner_q;
  logic [30:0]  rem_q;
  logic [59:0]  dsr_q;
  logic [4:0]   mcnt_q;
  logic         mbusy_q;

  logic [159:0] key, h_in, digest;
  logic [511:0] blk;
  logic         sha_busy;
  logic [3:0]   off;
  logic [30:0]  trunc;
  logic [31:0]  ctr_start;
  logic         rem_match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_mid_q  <= '0;
      key_low_q  <= '0;
      digits_q   <= 4'd6;
      window_q   <= 4'd1;
      offset_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegKeyHigh: key_high_q <= cfg_data_i;
        RegKeyMid:  key_mid_q  <= cfg_data_i;
        RegKeyLow:  key_low_q  <= cfg_data_i[31:0];
        RegDigits:  digits_q   <= cfg_data_i[3:0];
        RegWindow:  window_q   <= cfg_data_i[3:0];
        RegOffset:  offset_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign key = {key_high_q, key_mid_q, key_low_q};

  always_comb begin
    case (blk_q)
      BlkInnerKey: blk = {key ^ {20{8'h36}}, {44{8'h36}}};
      BlkInnerMsg: blk = {{32{ctr_q[31]}}, ctr_q, 32'h8000_0000, 352'b0, InnerLenBits};
      BlkOuterKey: blk = {key ^ {20{8'h5C}}, {44{8'h5C}}};
      default:     blk = {inner_q, 32'h8000_0000, 256'b0, OuterLenBits};
    endcase
    h_in = (blk_q == BlkInnerKey || blk_q == BlkOuterKey) ? Sha1Iv : hst_q;
  end

  totp_sha1 u_sha1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.sha_start),
    .h_i      (h_in),
    .blk_i    (blk),
    .busy_o   (sha_busy),
    .digest_o (digest)
  );

  // Dynamic truncation: the low nibble of the last MAC byte picks a 4-byte window,
  // whose top bit is dropped.
  assign off   = hst_q[3:0];
  assign trunc = hst_q[(8'd158 - {1'b0, off, 3'b000}) -: 31];

  assign ctr_start = {1'b0, minute_count_i} + {{16{offset_q[15]}}, offset_q}
                     - {28'b0, window_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      claimed_q <= claimed_code_i;
      ctr_q     <= ctr_start;
      sidx_q    <= '0;
      blk_q     <= BlkInnerKey;
    end else if (cmd_i.next_shift) begin
      ctr_q  <= ctr_q + 32'd1;
      sidx_q <= sidx_q + 5'd1;
    end else if (cmd_i.sha_capture) begin
      blk_q <= blk_q + 2'd1;
      if (blk_q == BlkInnerMsg) begin
        inner_q <= digest;
      end else begin
        hst_q <= digest;
      end
    end
    if (cmd_i.mod_start) begin
      rem_q  <= trunc;
      dsr_q  <= {pow10(digits_q), 30'b0};
      mcnt_q <= 5'd30;
    end else if (mbusy_q) begin
      if ({29'b0, rem_q} >= dsr_q) begin
        rem_q <= rem_q - dsr_q[30:0];
      end
      dsr_q  <= {1'b0, dsr_q[59:1]};
      mcnt_q <= mcnt_q - 5'd1;
    end
    if (cmd_i.result_set) begin
      code_matches_o <= sts_o.match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
    end else if (cmd_i.mod_start) begin
      // Moduli above nine digits exceed any 31-bit value, so no reduction is needed.
      mbusy_q <= (digits_q <= 4'd9);
    end else if (mbusy_q && mcnt_q == 5'd0) begin
      mbusy_q <= 1'b0;
    end
  end

  assign rem_match = (rem_q == {1'b0, claimed_q});

  assign sts_o.sha_done   = !sha_busy;
  assign sts_o.last_blk   = (blk_q == BlkOuterMsg);
  assign sts_o.mod_done   = !mbusy_q;
  assign sts_o.match      = rem_match;
  assign sts_o.last_shift = (sidx_q == {window_q, 1'b0});

endmodule
`default_nettype wire

[rtl/core/totp_ctrl.sv]
// Controller: sequences the four compressions, reduction and compare for each shift.
`default_nettype none
module totp_ctrl import totp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:    if (in_valid_i) state_d = StHashGo;
      StHashGo:  state_d = StHashRun;
      StHashRun: begin
        if (sts_i.sha_done) state_d = sts_i.last_blk ? StModGo : StHashGo;
      end
      StModGo:   state_d = StModRun;
      StModRun:  if (sts_i.mod_done) state_d = StCheck;
      StCheck: begin
        state_d = (sts_i.match || sts_i.last_shift) ? StReport : StHashGo;
      end
      StReport:  if (slot_free) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StHashGo:  cmd_o.sha_start = 1'b1;
      StHashRun: cmd_o.sha_capture = sts_i.sha_done;
      StModGo:   cmd_o.mod_start = 1'b1;
      StCheck:   cmd_o.next_shift = !(sts_i.match || sts_i.last_shift);
      StReport: begin
        if (slot_free) begin
          cmd_o.result_set = 1'b1;
          out_valid_d      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

[rtl/core/totp_window_verify.sv]
// Top level of the time-based one-time code verifier.
// Each transfer on the input channel carries a minute count and a claimed code; the block
// tries shifts from -drift_window to +drift_window around minute_count + user_offset, each
// an HMAC-SHA1 of four SHA-1 compressions on one shared round unit, each compression with
// its own start and capture, then a shift-subtract reduction modulo ten to the code_digits
// (skipped when code_digits is above nine, since no reduction is needed). The search stops
// at the first match. Items are handled one at a time; a result waits in an output register
// while the next item may already be taken. Configuration writes are always accepted and
// must be made only while the block is idle.
`default_nettype none
module totp_window_verify import totp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [30:0] minute_count_i,
  input  wire logic [29:0] claimed_code_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             code_matches_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  totp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  totp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .minute_count_i (minute_count_i),
    .claimed_code_i (claimed_code_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .code_matches_o (code_matches_o)
  );

endmodule
`default_nettype wire
